/* src/twtb_pkg.sv */
// Package for the two-way transposition bucket unit.
// Holds payload structs, function codes, entry layout and table sizes.
// No dependencies.
package twtb_pkg;

    localparam int BUCKET_COUNT = 1024;
    localparam int BUCKET_W = $clog2(BUCKET_COUNT);
    localparam int QUEUE_DEPTH = 2;
    localparam logic [6:0] NO_MOVE = 7'd64;
    localparam logic [7:0] OLD_AGE_RESET = 8'd4;

    typedef enum logic [1:0] {
        FUNC_UPDATE  = 2'd0,
        FUNC_LOOKUP  = 2'd1,
        FUNC_REFRESH = 2'd2,
        FUNC_CLEAR   = 2'd3
    } func_t;

    typedef struct packed {
        logic [1:0]  func;
        logic [9:0]  bucket;
        logic [63:0] player_bits;
        logic [63:0] opponent_bits;
        logic [5:0]  new_depth;
        logic [2:0]  new_selectivity;
        logic [7:0]  new_cost;
        logic signed [7:0] new_alpha;
        logic signed [7:0] new_beta;
        logic [6:0]  new_best_move;
        logic [6:0]  new_alt_move;
        logic [7:0]  stamp;
    } in_item_t;

    typedef struct packed {
        logic        hit;
        logic [5:0]  out_depth;
        logic [2:0]  out_selectivity;
        logic [7:0]  out_cost;
        logic signed [7:0] out_alpha;
        logic signed [7:0] out_beta;
        logic [6:0]  out_best_move;
        logic [6:0]  out_alt_move;
    } out_item_t;

    typedef struct packed {
        logic [5:0]  depth;
        logic [2:0]  sel;
        logic [7:0]  cost;
        logic signed [7:0] alpha;
        logic signed [7:0] beta;
        logic [6:0]  best;
        logic [6:0]  alt;
    } value_t;

    typedef struct packed {
        logic [63:0] kp;
        logic [63:0] ko;
        value_t      val;
        logic [7:0]  stamp;
    } entry_t;

    // Decoded job handed from the front to the back.
    typedef struct packed {
        func_t         func;
        logic [BUCKET_W-1:0] bucket;
        logic [63:0]   kp;
        logic [63:0]   ko;
        value_t        val;
        logic [7:0]    stamp;
    } job_t;

    localparam value_t CLEARED = '{depth: 6'd0, sel: 3'd0, cost: 8'd0, alpha: 8'sd0,
                                   beta: 8'sd0, best: NO_MOVE, alt: NO_MOVE};

endpackage

/* src/twtb_front.sv */
// Front end: accepts input transfers, decodes them into jobs and queues them.
// Depends on twtb_pkg.
module twtb_front
    import twtb_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  in_item_t in_data,
    output logic     job_valid,
    input  logic     job_ready,
    output job_t     job
);

    job_t q_reg [QUEUE_DEPTH];
    logic wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic push, pop;
    job_t decoded;

    always_comb
    begin
        decoded.func = func_t'(in_data.func);
        decoded.bucket = in_data.bucket[BUCKET_W-1:0];
        decoded.kp = in_data.player_bits;
        decoded.ko = in_data.opponent_bits;
        decoded.val.depth = in_data.new_depth;
        decoded.val.sel = in_data.new_selectivity;
        decoded.val.cost = in_data.new_cost;
        decoded.val.alpha = in_data.new_alpha;
        decoded.val.beta = in_data.new_beta;
        decoded.val.best = in_data.new_best_move;
        decoded.val.alt = in_data.new_alt_move;
        decoded.stamp = in_data.stamp;
    end

    assign in_ready = (count_reg != 2'(QUEUE_DEPTH));
    assign job_valid = (count_reg != 2'd0);
    assign job = q_reg[rd_ptr_reg];
    assign push = in_valid && in_ready;
    assign pop = job_valid && job_ready;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            q_reg[wr_ptr_reg] <= decoded;
    end

endmodule

/* src/twtb_back.sv */
// Back end: clears the table, then runs one read-modify-write per job.
// Depends on twtb_pkg.
module twtb_back
    import twtb_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cfg_we,
    input  logic [7:0] cfg_data,
    input  logic      job_valid,
    output logic      job_ready,
    input  job_t      job,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_data
);

    typedef enum logic [3:0] {
        ST_CLEAR = 4'b0001,
        ST_IDLE  = 4'b0010,
        ST_READ  = 4'b0100,
        ST_WRITE = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    logic [BUCKET_W-1:0] clr_reg, clr_next;
    logic [7:0] old_age_reg;
    job_t job_reg;
    entry_t mem1 [BUCKET_COUNT];
    entry_t mem2 [BUCKET_COUNT];
    entry_t e1_reg, e2_reg;
    entry_t w1, w2;
    logic we1, we2;
    logic [BUCKET_W-1:0] waddr;
    logic out_valid_reg;
    out_item_t out_reg, res;
    logic m1, m2, old1, old2;
    entry_t fresh;
    value_t mv1, mv2;

    function automatic value_t merge(value_t db, value_t nv);
        value_t r;
        r = db;
        if (nv.depth > db.depth || (nv.depth == db.depth && nv.sel < db.sel))
            r = nv;
        else if (nv.depth == db.depth && nv.sel == db.sel)
        begin
            if (nv.cost > db.cost) r.cost = nv.cost;
            if (nv.alpha > db.alpha) r.alpha = nv.alpha;
            if (nv.beta < db.beta) r.beta = nv.beta;
            if (nv.best != NO_MOVE) r.best = nv.best;
            if (nv.alt != NO_MOVE) r.alt = nv.alt;
        end
        return r;
    endfunction

    assign job_ready = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data = out_reg;

    always_comb
    begin
        m1 = (e1_reg.kp == job_reg.kp) && (e1_reg.ko == job_reg.ko);
        m2 = (e2_reg.kp == job_reg.kp) && (e2_reg.ko == job_reg.ko);
        old1 = (job_reg.stamp - e1_reg.stamp) >= old_age_reg;
        old2 = (job_reg.stamp - e2_reg.stamp) >= old_age_reg;
        fresh = '{kp: job_reg.kp, ko: job_reg.ko, val: job_reg.val, stamp: job_reg.stamp};
        mv1 = merge(e1_reg.val, job_reg.val);
        mv2 = merge(e2_reg.val, job_reg.val);
        w1 = e1_reg;
        w2 = e2_reg;
        res = '{hit: 1'b0, out_depth: 6'd0, out_selectivity: 3'd0, out_cost: 8'd0,
                out_alpha: 8'sd0, out_beta: 8'sd0, out_best_move: NO_MOVE,
                out_alt_move: NO_MOVE};
        unique case (job_reg.func)
            FUNC_UPDATE:
            begin
                if (m1)
                begin
                    w1.val = mv1;
                    w1.stamp = job_reg.stamp;
                end
                else if (m2)
                begin
                    w2.val = mv2;
                    w2.stamp = job_reg.stamp;
                end
                else if (job_reg.val.cost > e1_reg.val.cost)
                begin
                    w2 = e1_reg;
                    w1 = fresh;
                end
                else if (job_reg.val.cost > e2_reg.val.cost)
                    w2 = fresh;
                else if (old1 && old2)
                begin
                    w2 = e1_reg;
                    w1 = fresh;
                end
                else if (old2)
                    w2 = fresh;
                else if (old1)
                begin
                    w1 = e2_reg;
                    w2 = fresh;
                end
            end
            FUNC_LOOKUP:
            begin
                if (m1 || m2)
                begin
                    res.hit = 1'b1;
                    {res.out_depth, res.out_selectivity, res.out_cost, res.out_alpha,
                     res.out_beta, res.out_best_move, res.out_alt_move}
                        = m1 ? e1_reg.val : e2_reg.val;
                end
            end
            FUNC_REFRESH:
            begin
                res.hit = m1 || m2;
                if (m1)
                    w1.stamp = job_reg.stamp;
                else if (m2)
                    w2.stamp = job_reg.stamp;
            end
            FUNC_CLEAR:
            begin
                w1.val = CLEARED;
                w2.val = CLEARED;
            end
            default: ;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        clr_next = clr_reg;
        we1 = 1'b0;
        we2 = 1'b0;
        waddr = job_reg.bucket;
        unique case (state_reg)
            ST_CLEAR:
            begin
                we1 = 1'b1;
                we2 = 1'b1;
                waddr = clr_reg;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == BUCKET_W'(BUCKET_COUNT - 1))
                    state_next = ST_IDLE;
            end
            ST_IDLE:
                if (job_valid)
                    state_next = ST_READ;
            ST_READ:
                state_next = ST_WRITE;
            ST_WRITE:
                if (!out_valid_reg || out_ready)
                begin
                    we1 = 1'b1;
                    we2 = 1'b1;
                    state_next = ST_IDLE;
                end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            clr_reg <= '0;
            old_age_reg <= OLD_AGE_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg <= clr_next;
            if (cfg_we)
                old_age_reg <= cfg_data;
            if (state_reg == ST_WRITE && (!out_valid_reg || out_ready))
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Memory port: each bank reads one row in the read state and writes one row in the write or clear state.
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && job_valid)
            job_reg <= job;
        if (state_reg == ST_READ)
        begin
            e1_reg <= mem1[job_reg.bucket];
            e2_reg <= mem2[job_reg.bucket];
        end
        if (we1)
            mem1[waddr] <= (state_reg == ST_CLEAR)
                ? '{kp: 64'd0, ko: 64'd0, val: CLEARED, stamp: 8'd0} : w1;
        if (we2)
            mem2[waddr] <= (state_reg == ST_CLEAR)
                ? '{kp: 64'd0, ko: 64'd0, val: CLEARED, stamp: 8'd0} : w2;
        if (state_reg == ST_WRITE && (!out_valid_reg || out_ready))
            out_reg <= res;
    end

endmodule

/* src/two_way_transposition_bucket_unit.sv */
// Top level of the two-way transposition bucket unit.
// Depends on twtb_pkg, twtb_front and twtb_back.
//
//   channel  signals                  carries
//   input    in_valid/in_ready        in_item_t, one request
//   output   out_valid/out_ready      out_item_t, one response
//   config   cfg_we/cfg_data          old_age register
//
// Each item passes through the back end states idle, bucket read and write back;
// write back waits while a response is stalled, and no new item is taken before it.
// After reset a clearing pass sweeps all 1024 buckets of the table; items wait.
// The two-entry queue keeps taking items while a response is stalled, until full.
module two_way_transposition_bucket_unit
    import twtb_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_item_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_data,
    input  logic      cfg_we,
    input  logic [7:0] cfg_data
);

    logic job_valid, job_ready;
    job_t job;

    twtb_front u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .job_valid(job_valid), .job_ready(job_ready), .job(job)
    );

    twtb_back u_back (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_data(cfg_data),
        .job_valid(job_valid), .job_ready(job_ready), .job(job),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
    );

endmodule
